[rtl/core/srm_pkg.sv]
// srm_pkg: word types, request and status codes, opcodes and sizes for the
// small register machine; used by all modules but srm_ram, no dependencies
`default_nettype none

package srm_pkg;

    // sizes fixed by the word format
    localparam int REG_COUNT         = 32;
    localparam int REG_AW            = 5;
    localparam int DATA_W            = 16;
    localparam int OPC_LSB           = 28;
    localparam int DATA_WORDS_DEF    = 256;
    localparam int PROGRAM_WORDS_DEF = 256;

    // opcodes, bits 31:28 of the instruction
    localparam logic [3:0] OPC_HALT  = 4'd0;
    localparam logic [3:0] OPC_LOAD  = 4'd1;
    localparam logic [3:0] OPC_STORE = 4'd2;
    localparam logic [3:0] OPC_ADD   = 4'd3;
    localparam logic [3:0] OPC_SUB   = 4'd4;
    localparam logic [3:0] OPC_AND   = 4'd5;
    localparam logic [3:0] OPC_EQSEL = 4'd8;

    typedef enum logic [1:0] {
        REQ_EXEC  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_HALT    = 2'd1,
        ST_UNSUP   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MEM
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] instr_word;
        logic [7:0]  mem_index;
        logic [15:0] mem_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  pc_now;
        logic [1:0]  status;
        logic [15:0] written_value;
        logic [15:0] read_value;
    } t_out_word;

    // decode and execute outcome handed to the sequencer
    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] rval;
        logic              reg_we;
        logic              mem_we;
        logic              is_load;
        logic              halt_set;
        logic              pc_adv;
    } t_exec_res;

endpackage

`default_nettype wire

[rtl/core/srm_ram.sv]
// srm_ram: generic simple dual port ram, one write and one registered read
// port; no dependencies
`default_nettype none

module srm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/srm_alu.sv]
// srm_alu: decode and execute of one captured word, data address forming
// depends on srm_pkg
`default_nettype none

module srm_alu #(
    parameter int DATA_WORDS = srm_pkg::DATA_WORDS_DEF,
    localparam int DAW       = $clog2(DATA_WORDS)
) (
    input  wire srm_pkg::t_in_word               i_word,
    input  wire logic                            i_halted,
    input  wire logic [srm_pkg::DATA_W-1:0]      i_reg_a,
    input  wire logic [srm_pkg::DATA_W-1:0]      i_reg_b,
    input  wire logic [srm_pkg::DATA_W-1:0]      i_mem_rdata,
    output srm_pkg::t_exec_res                   o_res,
    output logic [DAW-1:0]                       o_mem_addr
);

    logic [3:0]  opc;
    logic [9:0]  off;
    logic [16:0] addr_sum;

    assign opc = i_word.instr_word[31:srm_pkg::OPC_LSB];
    assign off = i_word.instr_word[19:10];

    // base plus offset, wrapped to the data store (power of two depth)
    assign addr_sum   = 17'(off) + 17'(i_reg_a);
    assign o_mem_addr = DAW'(addr_sum);

    // result selection
    always_comb begin
        o_res          = '0;
        o_res.status   = srm_pkg::ST_DONE;
        case (srm_pkg::t_req'(i_word.req_type))
            srm_pkg::REQ_WRITE: begin
                o_res.wval = i_word.mem_value;
            end
            srm_pkg::REQ_READ: begin
                o_res.rval = i_mem_rdata;
            end
            srm_pkg::REQ_NONE: begin
                o_res.status = srm_pkg::ST_UNSUP;
            end
            default: begin
                if (i_halted) begin
                    o_res.status = srm_pkg::ST_IGNORED;
                end else begin
                    o_res.pc_adv = 1'b1;
                    case (opc)
                        srm_pkg::OPC_HALT: begin
                            o_res.status   = srm_pkg::ST_HALT;
                            o_res.halt_set = 1'b1;
                            o_res.pc_adv   = 1'b0;
                        end
                        srm_pkg::OPC_LOAD: begin
                            o_res.is_load = 1'b1;
                            o_res.reg_we  = 1'b1;
                            o_res.wval    = i_mem_rdata;
                        end
                        srm_pkg::OPC_STORE: begin
                            // port b carries the destination field for store
                            o_res.mem_we = 1'b1;
                            o_res.wval   = i_reg_b;
                        end
                        srm_pkg::OPC_ADD: begin
                            o_res.reg_we = 1'b1;
                            o_res.wval   = i_reg_a + i_reg_b;
                        end
                        srm_pkg::OPC_SUB: begin
                            o_res.reg_we = 1'b1;
                            o_res.wval   = i_reg_b - i_reg_a;
                        end
                        srm_pkg::OPC_AND: begin
                            o_res.reg_we = 1'b1;
                            o_res.wval   = i_reg_a & i_reg_b;
                        end
                        srm_pkg::OPC_EQSEL: begin
                            o_res.reg_we = 1'b1;
                            o_res.wval   = (i_reg_a == i_reg_b) ? (i_reg_a & i_reg_b)
                                                                : (i_reg_a | i_reg_b);
                        end
                        default: begin
                            o_res.status = srm_pkg::ST_UNSUP;
                            o_res.pc_adv = 1'b0;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/small_register_machine_step.sv]
// small_register_machine_step: top level, sequencer, register file and data
// store rams, output register; depends on srm_pkg, srm_ram, srm_alu
//
//   channel | valid      | ready       | word
//   --------+------------+-------------+-------------------------
//   in      | i_in_valid | o_in_ready  | i_in_data  (t_in_word)
//   out     | o_out_valid| i_out_ready | o_out_data (t_out_word)
//
// a word: register file read on accept, execute and writeback in S_EXEC;
// a load: address add and data store read in S_EXEC, writeback in S_MEM.
// one word in flight at a time; the next is taken while the result waits.
// after reset a clearing pass zeroes every word of both rams,
// no word is accepted during it.
// a stalled output holds execute/writeback until the output register frees.
// DATA_WORDS and PROGRAM_WORDS are powers of two.
`default_nettype none

module small_register_machine_step #(
    parameter int DATA_WORDS    = srm_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = srm_pkg::PROGRAM_WORDS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire srm_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output srm_pkg::t_out_word      o_out_data
);

    localparam int DAW       = $clog2(DATA_WORDS);
    localparam int PAW       = $clog2(PROGRAM_WORDS);
    localparam int CLR_WORDS = (DATA_WORDS > srm_pkg::REG_COUNT) ? DATA_WORDS
                                                                 : srm_pkg::REG_COUNT;
    localparam int CLW       = $clog2(CLR_WORDS);

    srm_pkg::t_state    r_state, n_state;
    logic [CLW-1:0]     r_clr_cnt;
    logic [PAW-1:0]     r_pc, n_pc;
    logic               r_halted;
    srm_pkg::t_in_word  r_word;
    logic               r_out_valid;
    srm_pkg::t_out_word r_out_data;

    logic               in_acc, out_free, fire, clearing;
    srm_pkg::t_exec_res res;
    logic [DAW-1:0]     ex_addr;

    logic [3:0]                     in_opc;
    logic [srm_pkg::REG_AW-1:0]     rf_raddr_a, rf_raddr_b, rf_waddr;
    logic                           rf_we;
    logic [srm_pkg::DATA_W-1:0]     rf_wdata, reg_a, reg_b;
    logic                           dm_we, dm_re;
    logic [DAW-1:0]                 dm_waddr, dm_raddr;
    logic [srm_pkg::DATA_W-1:0]     dm_wdata, dm_rdata;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign clearing = (r_state == srm_pkg::S_CLEAR);

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and finish strobe
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        fire       = 1'b0;
        case (r_state)
            srm_pkg::S_CLEAR: begin
                if (r_clr_cnt == CLW'(CLR_WORDS - 1)) begin
                    n_state = srm_pkg::S_IDLE;
                end
            end
            srm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = srm_pkg::S_EXEC;
                end
            end
            srm_pkg::S_EXEC: begin
                if (res.is_load) begin
                    n_state = srm_pkg::S_MEM;
                end else if (out_free) begin
                    fire    = 1'b1;
                    n_state = srm_pkg::S_IDLE;
                end
            end
            srm_pkg::S_MEM: begin
                if (out_free) begin
                    fire    = 1'b1;
                    n_state = srm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srm_pkg::S_CLEAR;
            end
        endcase
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_in_data;
        end
    end

    // program counter and halt flag
    assign n_pc = (fire && res.pc_adv) ? r_pc + 1'b1 : r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_halted <= 1'b0;
        end else if (fire) begin
            r_pc <= n_pc;
            if (res.halt_set) begin
                r_halted <= 1'b1;
            end
        end
    end

    // register file: two copies, one per read port
    assign in_opc     = i_in_data.instr_word[31:srm_pkg::OPC_LSB];
    assign rf_raddr_a = i_in_data.instr_word[9:5];
    assign rf_raddr_b = (in_opc == srm_pkg::OPC_STORE) ? i_in_data.instr_word[4:0]
                                                       : i_in_data.instr_word[24:20];
    assign rf_we      = clearing || (fire && res.reg_we);
    assign rf_waddr   = clearing ? srm_pkg::REG_AW'(r_clr_cnt) : r_word.instr_word[4:0];
    assign rf_wdata   = clearing ? '0 : res.wval;

    srm_ram #(
        .WIDTH (srm_pkg::DATA_W),
        .DEPTH (srm_pkg::REG_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (rf_raddr_a),
        .o_rdata (reg_a)
    );

    srm_ram #(
        .WIDTH (srm_pkg::DATA_W),
        .DEPTH (srm_pkg::REG_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (rf_raddr_b),
        .o_rdata (reg_b)
    );

    // data store: preload on accept, store on finish, zeroes while clearing
    always_comb begin
        dm_we    = 1'b0;
        dm_waddr = DAW'(r_clr_cnt);
        dm_wdata = '0;
        if (clearing) begin
            dm_we = 1'b1;
        end else if (in_acc && i_in_data.req_type == srm_pkg::REQ_WRITE) begin
            dm_we    = 1'b1;
            dm_waddr = DAW'(i_in_data.mem_index);
            dm_wdata = i_in_data.mem_value;
        end else if (fire && res.mem_we) begin
            dm_we    = 1'b1;
            dm_waddr = ex_addr;
            dm_wdata = res.wval;
        end
    end

    // readback on accept, load read from execute
    assign dm_re    = (in_acc && i_in_data.req_type == srm_pkg::REQ_READ)
                   || (r_state == srm_pkg::S_EXEC && res.is_load);
    assign dm_raddr = (r_state == srm_pkg::S_EXEC) ? ex_addr : DAW'(i_in_data.mem_index);

    srm_ram #(
        .WIDTH (srm_pkg::DATA_W),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    // execute
    srm_alu #(
        .DATA_WORDS (DATA_WORDS)
    ) u_alu (
        .i_word      (r_word),
        .i_halted    (r_halted),
        .i_reg_a     (reg_a),
        .i_reg_b     (reg_b),
        .i_mem_rdata (dm_rdata),
        .o_res       (res),
        .o_mem_addr  (ex_addr)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data.pc_now        <= 8'(n_pc);
            r_out_data.status        <= res.status;
            r_out_data.written_value <= res.wval;
            r_out_data.read_value    <= res.rval;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared");

    // an unsupported or ignored word leaves the pc alone
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (res.status == srm_pkg::ST_UNSUP || res.status == srm_pkg::ST_IGNORED))
        |=> (r_pc == $past(r_pc)))
        else $error("pc moved on unsupported or ignored word");

    // a result is only finished into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // accepted word goes to execute next
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == srm_pkg::S_EXEC))
        else $error("accepted word not executed");

    // register file is never written while a read is being issued
    a_rf_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !rf_we)
        else $error("register file read and write overlap");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for small_register_machine_step, random and directed
// words in and ready stalls out, checked against an in-bench machine predictor
// depends on srm_pkg and the rtl of small_register_machine_step
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srm_pkg::*;

    localparam int RANDOM_WORDS   = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    // words waiting to be offered, predicted results waiting to arrive
    t_in_word  request_q[$];
    t_out_word outcome_q[$];

    // predictor copy of the machine state
    logic [15:0] gpr_m[32];
    logic [15:0] dmem_m[256];
    logic [7:0]  pc_m;
    logic        halted_m;

    int words_taken  = 0;
    int results_seen = 0;
    int total_words  = 0;
    int errors       = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    small_register_machine_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #4 i_clk = ~i_clk;

    // one word through the machine: updates predictor state, returns the result
    function automatic t_out_word step_machine(input t_in_word w);
        t_out_word   r;
        logic [3:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rb;
        logic [4:0]  rh;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] sum;
        logic [7:0]  addr;
        logic        adv;
        r = '0;
        r.status = ST_DONE;
        case (t_req'(w.req_type))
            REQ_WRITE: begin
                dmem_m[w.mem_index] = w.mem_value;
                r.written_value = w.mem_value;
            end
            REQ_READ: begin
                r.read_value = dmem_m[w.mem_index];
            end
            REQ_NONE: begin
                r.status = ST_UNSUP;
            end
            default: begin
                if (halted_m) begin
                    r.status = ST_IGNORED;
                end else begin
                    opc  = w.instr_word[31:28];
                    rd   = w.instr_word[4:0];
                    rb   = w.instr_word[9:5];
                    rh   = w.instr_word[24:20];
                    a    = gpr_m[rb];
                    b    = gpr_m[rh];
                    // data address wraps to the store size
                    sum  = {6'b0, w.instr_word[19:10]} + a;
                    addr = sum[7:0];
                    adv  = 1'b1;
                    case (opc)
                        OPC_HALT: begin
                            halted_m = 1'b1;
                            r.status = ST_HALT;
                            adv = 1'b0;
                        end
                        OPC_LOAD: begin
                            r.written_value = dmem_m[addr];
                            gpr_m[rd] = r.written_value;
                        end
                        OPC_STORE: begin
                            r.written_value = gpr_m[rd];
                            dmem_m[addr] = r.written_value;
                        end
                        OPC_ADD: begin
                            r.written_value = a + b;
                            gpr_m[rd] = r.written_value;
                        end
                        OPC_SUB: begin
                            r.written_value = b - a;
                            gpr_m[rd] = r.written_value;
                        end
                        OPC_AND: begin
                            r.written_value = a & b;
                            gpr_m[rd] = r.written_value;
                        end
                        OPC_EQSEL: begin
                            r.written_value = (a == b) ? (a & b) : (a | b);
                            gpr_m[rd] = r.written_value;
                        end
                        default: begin
                            r.status = ST_UNSUP;
                            adv = 1'b0;
                        end
                    endcase
                    if (adv) begin
                        pc_m = pc_m + 8'd1;
                    end
                end
            end
        endcase
        r.pc_now = pc_m;
        return r;
    endfunction

    function automatic bit op_known(input logic [3:0] opc);
        case (opc)
            OPC_HALT, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB, OPC_AND, OPC_EQSEL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // execute word, unused fields random so every bit moves
    function automatic t_in_word make_exec(input logic [3:0] opc, input logic [4:0] rd,
                                           input logic [4:0] rb, input logic [4:0] rh,
                                           input logic [9:0] off);
        t_in_word w;
        w.req_type   = REQ_EXEC;
        w.instr_word = $urandom();
        w.instr_word[31:28] = opc;
        w.instr_word[24:20] = rh;
        w.instr_word[19:10] = off;
        w.instr_word[9:5]   = rb;
        w.instr_word[4:0]   = rd;
        w.mem_index = 8'($urandom());
        w.mem_value = 16'($urandom());
        return w;
    endfunction

    function automatic t_in_word make_side(input t_req req, input logic [7:0] idx,
                                           input logic [15:0] val);
        t_in_word w;
        w.req_type   = req;
        w.instr_word = $urandom();
        w.mem_index  = idx;
        w.mem_value  = val;
        return w;
    endfunction

    // idle length: none inside a window of each 256 words, else mostly short
    function automatic int pick_gap(input int n, input int phase);
        int k;
        if (((n + phase) % 256) < 64) begin
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 50) begin
            return 0;
        end else if (k < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_word random_word();
        int         k;
        logic [3:0] opc;
        logic [4:0] rb;
        logic [4:0] rh;
        logic [7:0] idx;
        logic [15:0] val;
        k   = $urandom_range(0, 99);
        idx = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom());
        val = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom());
        if (k < 20) begin
            return make_side(REQ_WRITE, idx, val);
        end else if (k < 30) begin
            return make_side(REQ_READ, idx, val);
        end else if (k < 33) begin
            return make_side(REQ_NONE, idx, val);
        end
        if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 5))
                0: opc = OPC_LOAD;
                1: opc = OPC_STORE;
                2: opc = OPC_ADD;
                3: opc = OPC_SUB;
                4: opc = OPC_AND;
                default: opc = OPC_EQSEL;
            endcase
        end else begin
            opc = 4'($urandom());
            // halt stays for the closing part
            if (opc == OPC_HALT) begin
                opc = OPC_ADD;
            end
        end
        rb = 5'($urandom());
        rh = ($urandom_range(0, 3) == 0) ? rb : 5'($urandom());
        return make_exec(opc, 5'($urandom()), rb, rh, 10'($urandom()));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] e,
                                 input logic [15:0] g);
        if (g !== e) begin
            report_mismatch($sformatf("%s expected %0h got %0h", name, e, g));
        end
    endtask

    // driver: offers queued words, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                outcome_q.push_back(step_machine(in_data));
                words_taken++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    in_data  <= request_q.pop_front();
                    in_valid <= 1'b1;
                    gap_left = pick_gap(words_taken, 0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word, drives ready with stalls and one long hold
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    exp_w = outcome_q.pop_front();
                    compare_field("pc_now", exp_w.pc_now, out_data.pc_now);
                    compare_field("status", exp_w.status, out_data.status);
                    compare_field("written_value", exp_w.written_value,
                                  out_data.written_value);
                    compare_field("read_value", exp_w.read_value, out_data.read_value);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = pick_gap(results_seen, 128);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL small_register_machine_step");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 32; i++) begin
            gpr_m[i] = '0;
        end
        for (int i = 0; i < 256; i++) begin
            dmem_m[i] = '0;
        end
        pc_m     = '0;
        halted_m = 1'b0;

        // directed: field extremes, every operation, address wrap
        request_q.push_back(make_side(REQ_WRITE, 8'h00, 16'hFFFF));
        request_q.push_back(make_side(REQ_WRITE, 8'hFF, 16'h8001));
        request_q.push_back(make_side(REQ_WRITE, 8'h05, 16'h1234));
        request_q.push_back(make_side(REQ_READ, 8'hFF, 16'h0000));
        request_q.push_back(make_side(REQ_READ, 8'h07, 16'hFFFF));
        request_q.push_back(make_exec(OPC_LOAD, 5'd1, 5'd0, 5'd0, 10'h000));
        request_q.push_back(make_exec(OPC_LOAD, 5'd2, 5'd1, 5'd31, 10'h3FF));
        request_q.push_back(make_exec(OPC_LOAD, 5'd3, 5'd0, 5'd0, 10'h005));
        request_q.push_back(make_exec(OPC_LOAD, 5'd31, 5'd0, 5'd0, 10'h0FF));
        request_q.push_back(make_exec(OPC_ADD, 5'd4, 5'd1, 5'd31, 10'h000));
        request_q.push_back(make_exec(OPC_SUB, 5'd5, 5'd1, 5'd3, 10'h3FF));
        request_q.push_back(make_exec(OPC_AND, 5'd6, 5'd3, 5'd31, 10'h155));
        request_q.push_back(make_exec(OPC_EQSEL, 5'd7, 5'd3, 5'd3, 10'h2AA));
        request_q.push_back(make_exec(OPC_EQSEL, 5'd8, 5'd1, 5'd3, 10'h000));
        request_q.push_back(make_exec(OPC_STORE, 5'd4, 5'd31, 5'd0, 10'h3FF));
        request_q.push_back(make_side(REQ_READ, 8'h00, 16'h0000));
        for (int op = 0; op < 16; op++) begin
            if (!op_known(4'(op))) begin
                request_q.push_back(make_exec(4'(op), 5'($urandom()), 5'($urandom()),
                                              5'($urandom()), 10'($urandom())));
            end
        end
        request_q.push_back(make_side(REQ_NONE, 8'hFF, 16'hFFFF));

        // random mix of execute and side requests
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            request_q.push_back(random_word());
        end

        // halt last, then everything is ignored except side requests
        request_q.push_back(make_exec(OPC_HALT, 5'($urandom()), 5'($urandom()),
                                      5'($urandom()), 10'($urandom())));
        request_q.push_back(make_exec(OPC_ADD, 5'd9, 5'd1, 5'd3, 10'h000));
        request_q.push_back(make_exec(OPC_LOAD, 5'd9, 5'd0, 5'd0, 10'h3FF));
        request_q.push_back(make_exec(OPC_HALT, 5'd0, 5'd0, 5'd0, 10'h000));
        request_q.push_back(make_side(REQ_WRITE, 8'h80, 16'hA5A5));
        request_q.push_back(make_side(REQ_READ, 8'h80, 16'h0000));
        request_q.push_back(make_side(REQ_NONE, 8'h00, 16'h0000));
        for (int i = 0; i < 6; i++) begin
            request_q.push_back(random_word());
        end
        total_words = request_q.size();

        // hold synchronous reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all words taken, all results back, then a short quiet spell
        while (words_taken != total_words) @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS small_register_machine_step");
        end else begin
            $display("FAIL small_register_machine_step");
        end
        $finish;
    end

endmodule
